// ===== sv/pmrb_pkg.sv =====
// Shared types, constants and the angle-to-slot function of the polar minimum-range binner.
// Used by every module of the block; depends on nothing.

package pmrb_pkg;

  localparam int SLOT_COUNT      = 360;
  localparam int SLOT_W          = $clog2(SLOT_COUNT);
  localparam int ROW_COUNT       = SLOT_COUNT / 2;
  localparam int ROW_W           = $clog2(ROW_COUNT);
  localparam int ANGLE_FRAC_BITS = 4;
  localparam int ANGLE_W         = 16;
  localparam int DIST_W          = 16;
  localparam int ACTION_W        = 2;
  localparam int STATUS_W        = 2;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 16;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [DIST_W-1:0] MIN_RANGE_RESET = DIST_W'(20);
  localparam logic [DIST_W-1:0] MAX_RANGE_RESET = DIST_W'(16000);

  localparam int FULL_TURN   = 360 << ANGLE_FRAC_BITS;
  localparam int HALF_TURN   = 180 << ANGLE_FRAC_BITS;
  localparam int HALF_STEP   = (1 << ANGLE_FRAC_BITS) >> 1;
  localparam int BIAS_TURNS  = (32768 + FULL_TURN - 1) / FULL_TURN;
  localparam int ANGLE_BIAS  = BIAS_TURNS * FULL_TURN + HALF_TURN;
  localparam int POS_MAX     = 32767 + ANGLE_BIAS;
  localparam int POS_W       = $clog2(POS_MAX + 1);
  localparam int TURN_MAX    = POS_MAX / FULL_TURN;
  localparam int TURN_W      = $clog2(TURN_MAX + 1);
  localparam int REM_W       = $clog2(FULL_TURN + HALF_STEP);
  localparam int DEG_W       = REM_W - ANGLE_FRAC_BITS;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD   = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_STORED     = 2'd0,
    ST_NOT_NEARER = 2'd1,
    ST_ZERO       = 2'd2,
    ST_RANGE      = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_RANGE = 1'b0,
    CFG_MAX_RANGE = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CMD_UPDATE = 2'd0,
    CMD_REPORT = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_BLANK  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [SLOT_W-1:0] slot;
    logic [DIST_W-1:0] dist_mm;
    status_t           status;
  } entry_t;

  typedef struct packed {
    logic [1:0]             filled;
    logic [1:0][DIST_W-1:0] dist_mm;
  } row_t;

  // The angle is biased to a positive value, folded into one turn by
  // comparing against whole-turn multiples, then rounded to a degree.
  function automatic logic [SLOT_W-1:0] angle_to_slot(input logic signed [ANGLE_W-1:0] angle);
    logic [POS_W-1:0]  pos;
    logic [TURN_W-1:0] turns;
    logic [POS_W-1:0]  rem_full;
    logic [REM_W-1:0]  rnd;
    logic [DEG_W-1:0]  deg;
    pos   = POS_W'(ANGLE_BIAS) + POS_W'(angle);
    turns = '0;
    for (int k = 1; k <= TURN_MAX; k++) begin
      if (pos >= POS_W'(k * FULL_TURN)) begin
        turns = TURN_W'(k);
      end
    end
    rem_full = pos - POS_W'(turns * FULL_TURN);
    rnd      = REM_W'(rem_full) + REM_W'(HALF_STEP);
    deg      = rnd[REM_W-1:ANGLE_FRAC_BITS];
    if (deg >= DEG_W'(SLOT_COUNT)) begin
      return SLOT_W'(SLOT_COUNT - 1);
    end
    return SLOT_W'(deg);
  endfunction

endpackage

// ===== sv/pmrb_if.sv =====
// Handshake interfaces for the point input channel and the slot result channel.
// Depends on pmrb_pkg for field widths.

interface pmrb_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [pmrb_pkg::ACTION_W-1:0]        action;
  logic signed [pmrb_pkg::ANGLE_W-1:0]  angle_sixteenths;
  logic [pmrb_pkg::DIST_W-1:0]          point_distance_mm;
  logic [pmrb_pkg::SLOT_W-1:0]          read_slot;

  modport source (output valid, action, angle_sixteenths, point_distance_mm, read_slot,
                  input ready);
  modport sink   (input valid, action, angle_sixteenths, point_distance_mm, read_slot,
                  output ready);
endinterface

interface pmrb_out_if;
  logic                          valid;
  logic                          ready;
  logic [pmrb_pkg::SLOT_W-1:0]   slot_index;
  logic [pmrb_pkg::DIST_W-1:0]   slot_distance_mm;
  logic                          slot_empty;
  logic [pmrb_pkg::STATUS_W-1:0] point_status;

  modport source (output valid, slot_index, slot_distance_mm, slot_empty, point_status,
                  input ready);
  modport sink   (input valid, slot_index, slot_distance_mm, slot_empty, point_status,
                  output ready);
endinterface

// ===== sv/pmrb_front.sv =====
// Front end: holds the range registers, decodes each input transfer and classifies it.
// Depends on pmrb_pkg and pmrb_in_if; feeds pmrb_queue.

module pmrb_front (
  input  logic                            clk,
  input  logic                            rst_n,
  pmrb_in_if.sink                         in_ch,
  input  logic                            cfg_we,
  input  logic [pmrb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pmrb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic                            push_valid,
  output pmrb_pkg::entry_t                push_entry,
  input  logic                            push_ready
);

  logic [pmrb_pkg::DIST_W-1:0] min_range_r;
  logic [pmrb_pkg::DIST_W-1:0] max_range_r;
  logic [pmrb_pkg::DIST_W-1:0] point_dist;
  logic                        in_range;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_range_r <= pmrb_pkg::MIN_RANGE_RESET;
      max_range_r <= pmrb_pkg::MAX_RANGE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pmrb_pkg::CFG_MIN_RANGE: min_range_r <= cfg_wdata[pmrb_pkg::DIST_W-1:0];
        pmrb_pkg::CFG_MAX_RANGE: max_range_r <= cfg_wdata[pmrb_pkg::DIST_W-1:0];
        default: ;
      endcase
    end
  end

  assign point_dist  = in_ch.point_distance_mm;
  assign in_range    = (point_dist >= min_range_r) && (point_dist <= max_range_r);
  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;

  always_comb begin
    push_entry         = '0;
    push_entry.dist_mm = point_dist;
    push_entry.status  = pmrb_pkg::ST_STORED;
    unique case (in_ch.action)
      pmrb_pkg::ACT_ADD: begin
        push_entry.slot = pmrb_pkg::angle_to_slot(in_ch.angle_sixteenths);
        if (point_dist == '0) begin
          push_entry.cmd    = pmrb_pkg::CMD_REPORT;
          push_entry.status = pmrb_pkg::ST_ZERO;
        end else if (!in_range) begin
          push_entry.cmd    = pmrb_pkg::CMD_REPORT;
          push_entry.status = pmrb_pkg::ST_RANGE;
        end else begin
          push_entry.cmd = pmrb_pkg::CMD_UPDATE;
        end
      end
      pmrb_pkg::ACT_READ: begin
        push_entry.cmd = pmrb_pkg::CMD_REPORT;
        if (in_ch.read_slot >= pmrb_pkg::SLOT_W'(pmrb_pkg::SLOT_COUNT)) begin
          push_entry.slot = pmrb_pkg::SLOT_W'(pmrb_pkg::SLOT_COUNT - 1);
        end else begin
          push_entry.slot = in_ch.read_slot;
        end
      end
      pmrb_pkg::ACT_CLEAR: begin
        push_entry.cmd = pmrb_pkg::CMD_CLEAR;
      end
      default: begin
        push_entry.cmd = pmrb_pkg::CMD_BLANK;
      end
    endcase
  end

endmodule

// ===== sv/pmrb_queue.sv =====
// Short first-in first-out queue of decoded commands between front end and back end.
// Depends on pmrb_pkg for the entry type.

module pmrb_queue #(
  parameter int DEPTH = pmrb_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  input  pmrb_pkg::entry_t push_entry,
  output logic             push_ready,
  output logic             pop_valid,
  output pmrb_pkg::entry_t pop_entry,
  input  logic             pop
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  pmrb_pkg::entry_t  slots_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== sv/pmrb_back.sv =====
// Back end: read-modify-write of the slot memory and the registered result stage.
// Depends on pmrb_pkg and pmrb_out_if; fed by pmrb_queue.

module pmrb_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pop_valid,
  input  pmrb_pkg::entry_t pop_entry,
  output logic             pop,
  pmrb_out_if.source       out_ch
);

  typedef enum logic [1:0] {
    BK_IDLE = 2'b01,
    BK_EXEC = 2'b10
  } back_state_t;

  back_state_t                  state_r;
  back_state_t                  state_nxt;
  pmrb_pkg::row_t               mem [pmrb_pkg::ROW_COUNT];
  pmrb_pkg::row_t               rd_row_r;
  pmrb_pkg::entry_t             cur_r;
  logic [pmrb_pkg::ROW_COUNT-1:0] row_valid_r;

  logic                         out_valid_r;
  logic [pmrb_pkg::SLOT_W-1:0]  out_slot_r;
  logic [pmrb_pkg::DIST_W-1:0]  out_dist_r;
  logic                         out_empty_r;
  pmrb_pkg::status_t            out_status_r;

  logic [pmrb_pkg::ROW_W-1:0]   row;
  logic                         lane;
  logic                         row_live;
  logic                         old_filled;
  logic [pmrb_pkg::DIST_W-1:0]  old_dist;
  logic                         nearer;
  logic                         fire;
  logic                         mem_we;
  pmrb_pkg::row_t               wr_row;
  logic [pmrb_pkg::SLOT_W-1:0]  res_slot;
  logic [pmrb_pkg::DIST_W-1:0]  res_dist;
  logic                         res_empty;
  pmrb_pkg::status_t            res_status;

  assign row        = cur_r.slot[pmrb_pkg::SLOT_W-1:1];
  assign lane       = cur_r.slot[0];
  assign row_live   = row_valid_r[row];
  assign old_filled = row_live && rd_row_r.filled[lane];
  assign old_dist   = rd_row_r.dist_mm[lane];
  assign nearer     = !old_filled || (cur_r.dist_mm < old_dist);
  assign fire       = (state_r == BK_EXEC) && (!out_valid_r || out_ch.ready);
  assign mem_we     = fire && (cur_r.cmd == pmrb_pkg::CMD_UPDATE) && nearer;
  assign pop        = (state_r == BK_IDLE) && pop_valid;

  always_comb begin
    wr_row = rd_row_r;
    if (!row_live) begin
      wr_row.filled = '0;
    end
    wr_row.filled[lane]  = 1'b1;
    wr_row.dist_mm[lane] = cur_r.dist_mm;
  end

  always_comb begin
    res_slot   = cur_r.slot;
    res_dist   = '0;
    res_empty  = 1'b1;
    res_status = pmrb_pkg::ST_STORED;
    unique case (cur_r.cmd)
      pmrb_pkg::CMD_UPDATE: begin
        res_empty = 1'b0;
        if (nearer) begin
          res_dist   = cur_r.dist_mm;
          res_status = pmrb_pkg::ST_STORED;
        end else begin
          res_dist   = old_dist;
          res_status = pmrb_pkg::ST_NOT_NEARER;
        end
      end
      pmrb_pkg::CMD_REPORT: begin
        res_dist   = old_filled ? old_dist : '0;
        res_empty  = !old_filled;
        res_status = cur_r.status;
      end
      default: begin
        res_slot = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (pop_valid) state_nxt = BK_EXEC;
      BK_EXEC: if (fire) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[row] <= wr_row;
    end
    if (pop) begin
      rd_row_r <= mem[pop_entry.slot[pmrb_pkg::SLOT_W-1:1]];
      cur_r    <= pop_entry;
    end
    if (fire) begin
      out_slot_r   <= res_slot;
      out_dist_r   <= res_dist;
      out_empty_r  <= res_empty;
      out_status_r <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      row_valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fire && (cur_r.cmd == pmrb_pkg::CMD_CLEAR)) begin
        row_valid_r <= '0;
      end else if (mem_we) begin
        row_valid_r[row] <= 1'b1;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.slot_index       = out_slot_r;
  assign out_ch.slot_distance_mm = out_dist_r;
  assign out_ch.slot_empty       = out_empty_r;
  assign out_ch.point_status     = out_status_r;

endmodule

// ===== sv/polar_min_range_binner.sv =====
// Top level of the polar minimum-range binner: front end, command queue and back end.
// Depends on pmrb_pkg, pmrb_if, pmrb_front, pmrb_queue and pmrb_back.
//
//   Channel  Direction  Handshake           Payload
//   in_ch    input      valid/ready         action, angle_sixteenths, point_distance_mm,
//                                           read_slot
//   out_ch   output     valid/ready         slot_index, slot_distance_mm, slot_empty,
//                                           point_status
//   cfg_*    input      cfg_we, no wait     cfg_index, cfg_wdata
//
// Every item passes through a row read of the slot memory in BK_IDLE, then the compare,
// write-back and result load in BK_EXEC; the back end takes no new item until that one fires.
// A result passes through the queue, the back-end row registers and the output registers.
// Reset is synchronous and empties every slot at once through per-row valid bits.
// The queue holds QUEUE_DEPTH decoded items, so input transfers continue while a result
// waits on out_ch.ready, until the queue is full.

module polar_min_range_binner #(
  parameter int QUEUE_DEPTH = pmrb_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  pmrb_in_if.sink                         in_ch,
  pmrb_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [pmrb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pmrb_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic             push_valid;
  logic             push_ready;
  pmrb_pkg::entry_t push_entry;
  logic             pop_valid;
  logic             pop;
  pmrb_pkg::entry_t pop_entry;

  pmrb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  pmrb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry),
    .pop        (pop)
  );

  pmrb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_entry (pop_entry),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

// ===== sv/pmrb_checker.sv =====
// Port-level checker for the polar minimum-range binner and its bind to the top level.
// Depends on pmrb_pkg and polar_min_range_binner.

module pmrb_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [pmrb_pkg::SLOT_W-1:0]    slot_index,
  input logic [pmrb_pkg::DIST_W-1:0]    slot_distance_mm,
  input logic                           slot_empty,
  input logic [pmrb_pkg::STATUS_W-1:0]  point_status
);

  logic [7:0] pending_r;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (in_xfer && !out_xfer) begin
      pending_r <= pending_r + 1'b1;
    end else if (out_xfer && !in_xfer) begin
      pending_r <= pending_r - 1'b1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(slot_index)
      && $stable(slot_distance_mm) && $stable(slot_empty) && $stable(point_status))
    else $error("result changed while stalled");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != '0)
    else $error("result shown with no transfer outstanding");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && slot_empty |-> slot_distance_mm == '0)
    else $error("empty slot reported with a distance");

  a_not_nearer_filled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (point_status == pmrb_pkg::ST_NOT_NEARER) |-> !slot_empty
      && slot_index < pmrb_pkg::SLOT_W'(pmrb_pkg::SLOT_COUNT))
    else $error("not-nearer status on an empty or invalid slot");

endmodule

bind polar_min_range_binner pmrb_checker u_pmrb_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .slot_index       (out_ch.slot_index),
  .slot_distance_mm (out_ch.slot_distance_mm),
  .slot_empty       (out_ch.slot_empty),
  .point_status     (out_ch.point_status)
);
